/* rtl/tmp_pkg.sv */
// Package: shared types, constants and the microprogram of the trapezoid move profile block.
package tmp_pkg;

   localparam int VEL_W  = 22;
   localparam int DIST_W = 33;
   localparam int TGT_W  = 32;
   localparam int ENDV_W = 20;
   localparam int MAXV_W = 20;
   localparam int STEP_SZ_W = 16;
   localparam int PH_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_STEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL_STEP   = 2'd2;

   localparam logic [MAXV_W-1:0]    MAXV_RESET  = 20'd262144;
   localparam logic [STEP_SZ_W-1:0] ACCEL_RESET = 16'd256;
   localparam logic [STEP_SZ_W-1:0] DECEL_RESET = 16'd256;

   typedef enum logic [PH_W-1:0] {
      PH_IDLE   = 3'd0,
      PH_ACCEL  = 3'd1,
      PH_CRUISE = 3'd2,
      PH_DECEL  = 3'd3,
      PH_COAST  = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LOAD,
      UOP_VEL,
      UOP_DIST,
      UOP_MUL_VV,
      UOP_MUL_EE,
      UOP_MUL_RHS,
      UOP_SETTLE,
      UOP_RESPOND
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_START,
      COND_IDLE,
      COND_ALWAYS
   } cond_type;

   localparam int UC_DEPTH = 10;
   localparam int STEP_W   = $clog2(UC_DEPTH);
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_DISPATCH = 4'd0;
   localparam step_type ST_IDLECHK  = 4'd1;
   localparam step_type ST_VEL      = 4'd2;
   localparam step_type ST_DIST     = 4'd3;
   localparam step_type ST_LOAD     = 4'd4;
   localparam step_type ST_MUL_VV   = 4'd5;
   localparam step_type ST_MUL_EE   = 4'd6;
   localparam step_type ST_MUL_RHS  = 4'd7;
   localparam step_type ST_SETTLE   = 4'd8;
   localparam step_type ST_RESPOND  = 4'd9;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     last;
   } ctrl_word_type;

   // Datapath command from the sequencer.
   typedef struct packed {
      logic   exec;
      op_type op;
   } dp_ctrl_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic start_item;
      logic phase_idle;
      logic out_free;
   } dp_status_type;

   // The microprogram. A start request runs LOAD and the settle sequence; a tick
   // in a move runs the motion update first; a tick while idle only responds.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '{op: UOP_NONE, cond: COND_NEXT, target: ST_DISPATCH, last: 1'b0};
      case (step)
         ST_DISPATCH: w = '{op: UOP_NONE,    cond: COND_START,  target: ST_LOAD,    last: 1'b0};
         ST_IDLECHK:  w = '{op: UOP_NONE,    cond: COND_IDLE,   target: ST_RESPOND, last: 1'b0};
         ST_VEL:      w = '{op: UOP_VEL,     cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b0};
         ST_DIST:     w = '{op: UOP_DIST,    cond: COND_ALWAYS, target: ST_MUL_VV,  last: 1'b0};
         ST_LOAD:     w = '{op: UOP_LOAD,    cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b0};
         ST_MUL_VV:   w = '{op: UOP_MUL_VV,  cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b0};
         ST_MUL_EE:   w = '{op: UOP_MUL_EE,  cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b0};
         ST_MUL_RHS:  w = '{op: UOP_MUL_RHS, cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b0};
         ST_SETTLE:   w = '{op: UOP_SETTLE,  cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b0};
         ST_RESPOND:  w = '{op: UOP_RESPOND, cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b1};
         default:     w = '{op: UOP_RESPOND, cond: COND_NEXT,   target: ST_DISPATCH, last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

/* rtl/tmp_channels.sv */
// Interfaces: request and response channels of the trapezoid move profile block.
interface tmp_req_if;
   import tmp_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [TGT_W-1:0]  target_distance;
   logic [ENDV_W-1:0] exit_velocity;

   modport source(output valid, action, target_distance, exit_velocity, input ready);
   modport sink(input valid, action, target_distance, exit_velocity, output ready);
endinterface

interface tmp_rsp_if;
   import tmp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [VEL_W-1:0]  velocity_now;
   logic [TGT_W-1:0]         distance_now;
   logic [PH_W-1:0]          phase;
   logic                     done_res;

   modport source(output valid, velocity_now, distance_now, phase, done_res, input ready);
   modport sink(input valid, velocity_now, distance_now, phase, done_res, output ready);
endinterface

/* rtl/tmp_sequencer.sv */
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module tmp_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  tmp_pkg::dp_status_type status,
   output logic                   ready,
   output tmp_pkg::dp_ctrl_type   ctrl
);
   import tmp_pkg::*;

   logic          busy_ff, busy_in;
   step_type      step_ff, step_in;
   ctrl_word_type word;
   logic          stall;
   logic          jump;

   always_comb begin
      word  = ucode_rom(step_ff);
      stall = (word.op == UOP_RESPOND) && !status.out_free;
      case (word.cond)
         COND_START:  jump = status.start_item;
         COND_IDLE:   jump = status.phase_idle;
         COND_ALWAYS: jump = 1'b1;
         default:     jump = 1'b0;
      endcase

      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (accept) begin
            busy_in = 1'b1;
            step_in = ST_DISPATCH;
         end
      end else if (!stall) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else if (jump) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ST_DISPATCH;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ready     = !busy_ff;
   assign ctrl.exec = busy_ff && !stall;
   assign ctrl.op   = word.op;

endmodule

/* rtl/tmp_datapath.sv */
// Datapath: move state, configuration, shared multiplier, phase logic and response register.
module tmp_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 req_action,
   input  logic [tmp_pkg::TGT_W-1:0]            req_target_distance,
   input  logic [tmp_pkg::ENDV_W-1:0]           req_exit_velocity,
   input  logic                                 csr_we,
   input  logic [tmp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tmp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  tmp_pkg::dp_ctrl_type                 ctrl,
   output tmp_pkg::dp_status_type               status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [tmp_pkg::VEL_W-1:0]     rsp_velocity_now,
   output logic [tmp_pkg::TGT_W-1:0]            rsp_distance_now,
   output logic [tmp_pkg::PH_W-1:0]             rsp_phase,
   output logic                                 rsp_done_res
);
   import tmp_pkg::*;

   localparam logic signed [VEL_W+1:0]  VSUM_MAX = 24'sd2097151;
   localparam logic signed [VEL_W+1:0]  VSUM_MIN = -24'sd2097152;
   localparam logic signed [DIST_W+1:0] ND_MAX   = $signed({2'b00, {DIST_W{1'b1}}});

   // Configuration
   logic [MAXV_W-1:0]    maxv_ff;
   logic [STEP_SZ_W-1:0] accel_ff, decel_ff;

   // Request latch
   logic              act_ff;
   logic [TGT_W-1:0]  tgt_ff;
   logic [ENDV_W-1:0] endv_ff;

   // Move state
   logic signed [VEL_W-1:0] vel_ff, vel_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   phase_type               phase_ff, phase_in;
   logic [TGT_W-1:0]        goal_ff;
   logic [ENDV_W-1:0]       gev_ff;
   logic                    done_ff, done_in;

   // Products and brake test terms
   logic [43:0] vv_ff;
   logic [39:0] ee_ff;
   logic [43:0] lhs_ff;
   logic [48:0] rhs_ff;

   logic [31:0] mul_a;
   logic [21:0] mul_b;
   logic [53:0] mul_p;
   logic [VEL_W-1:0] vabs;
   logic [TGT_W-1:0] diff;

   logic signed [VEL_W+1:0]  acc;
   logic signed [VEL_W+1:0]  vsum;
   logic signed [VEL_W-1:0]  vsat;
   logic signed [DIST_W+1:0] nd;
   logic [DIST_W-1:0]        dsat;

   logic ge_goal, gt_goal, brake, v_le_gev, v_ge_max;

   logic rsp_valid_ff;
   logic signed [VEL_W-1:0] rsp_vel_ff;
   logic [TGT_W-1:0]        rsp_dist_ff;
   logic [PH_W-1:0]         rsp_phase_ff;
   logic                    rsp_done_ff;

   // Motion update terms
   always_comb begin
      case (phase_ff)
         PH_ACCEL: acc = $signed({8'b0, accel_ff});
         PH_DECEL: acc = -$signed({8'b0, decel_ff});
         default:  acc = '0;
      endcase
      vsum = $signed({{2{vel_ff[VEL_W-1]}}, vel_ff}) + acc;
      if (vsum > VSUM_MAX) begin
         vsat = VSUM_MAX[VEL_W-1:0];
      end else if (vsum < VSUM_MIN) begin
         vsat = VSUM_MIN[VEL_W-1:0];
      end else begin
         vsat = vsum[VEL_W-1:0];
      end

      nd = $signed({2'b00, dist_ff}) + $signed({{(DIST_W+2-VEL_W){vel_ff[VEL_W-1]}}, vel_ff});
      if (nd < 0) begin
         dsat = '0;
      end else if (nd > ND_MAX) begin
         dsat = '1;
      end else begin
         dsat = nd[DIST_W-1:0];
      end
   end

   // Shared multiplier, one product per microstep
   always_comb begin
      vabs = vel_ff[VEL_W-1] ? VEL_W'(-vel_ff) : VEL_W'(vel_ff);
      diff = goal_ff - dist_ff[TGT_W-1:0];
      case (ctrl.op)
         UOP_MUL_VV: begin
            mul_a = {10'b0, vabs};
            mul_b = vabs;
         end
         UOP_MUL_EE: begin
            mul_a = {12'b0, gev_ff};
            mul_b = {2'b0, gev_ff};
         end
         default: begin
            mul_a = diff;
            mul_b = {6'b0, decel_ff};
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Phase transitions of one settle pass
   always_comb begin
      ge_goal  = dist_ff >= {1'b0, goal_ff};
      gt_goal  = dist_ff > {1'b0, goal_ff};
      brake    = ge_goal || ({5'b0, lhs_ff} >= rhs_ff);
      v_le_gev = vel_ff <= $signed({2'b00, gev_ff});
      v_ge_max = vel_ff >= $signed({2'b00, maxv_ff});

      vel_in   = vel_ff;
      dist_in  = dist_ff;
      phase_in = phase_ff;
      done_in  = done_ff;

      if (phase_in == PH_ACCEL || phase_in == PH_CRUISE) begin
         if (brake) begin
            phase_in = PH_DECEL;
         end else if (phase_in == PH_ACCEL && v_ge_max) begin
            phase_in = PH_CRUISE;
         end
      end
      if (phase_in == PH_DECEL) begin
         if (v_le_gev || gt_goal) begin
            vel_in = $signed({2'b00, gev_ff});
            if (gev_ff != '0) begin
               phase_in = PH_COAST;
            end else begin
               phase_in = PH_IDLE;
               dist_in  = '0;
               done_in  = 1'b1;
            end
         end
      end
      if (phase_in == PH_COAST && ge_goal) begin
         phase_in = PH_IDLE;
         dist_in  = '0;
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxv_ff      <= MAXV_RESET;
         accel_ff     <= ACCEL_RESET;
         decel_ff     <= DECEL_RESET;
         vel_ff       <= '0;
         dist_ff      <= '0;
         phase_ff     <= PH_IDLE;
         goal_ff      <= '0;
         gev_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CRUISE_LIMIT: maxv_ff  <= csr_wdata;
               CSR_ACCEL_STEP:   accel_ff <= csr_wdata[STEP_SZ_W-1:0];
               CSR_DECEL_STEP:   decel_ff <= csr_wdata[STEP_SZ_W-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            act_ff  <= req_action;
            tgt_ff  <= req_target_distance;
            endv_ff <= req_exit_velocity;
            done_ff <= 1'b0;
         end

         if (ctrl.exec) begin
            case (ctrl.op)
               UOP_LOAD: begin
                  goal_ff  <= tgt_ff;
                  gev_ff   <= endv_ff;
                  phase_ff <= PH_ACCEL;
               end
               UOP_VEL:    vel_ff  <= vsat;
               UOP_DIST:   dist_ff <= dsat;
               UOP_MUL_VV: vv_ff   <= mul_p[43:0];
               UOP_MUL_EE: ee_ff   <= mul_p[39:0];
               UOP_MUL_RHS: begin
                  rhs_ff <= {mul_p[47:0], 1'b0};
                  lhs_ff <= (vv_ff >= {4'b0, ee_ff}) ? (vv_ff - {4'b0, ee_ff})
                                                     : ({4'b0, ee_ff} - vv_ff);
               end
               UOP_SETTLE: begin
                  vel_ff   <= vel_in;
                  dist_ff  <= dist_in;
                  phase_ff <= phase_in;
                  done_ff  <= done_in;
               end
               default: ;
            endcase
         end

         if (ctrl.exec && ctrl.op == UOP_RESPOND) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (ctrl.exec && ctrl.op == UOP_RESPOND) begin
         rsp_vel_ff   <= vel_ff;
         rsp_dist_ff  <= dist_ff[DIST_W-1] ? '1 : dist_ff[TGT_W-1:0];
         rsp_phase_ff <= phase_ff;
         rsp_done_ff  <= done_ff;
      end
   end

   assign status.start_item = act_ff;
   assign status.phase_idle = (phase_ff == PH_IDLE);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_velocity_now = rsp_vel_ff;
   assign rsp_distance_now = rsp_dist_ff;
   assign rsp_phase        = rsp_phase_ff;
   assign rsp_done_res     = rsp_done_ff;

endmodule

/* rtl/trapezoid_move_profile_core.sv */
// Top level: trapezoidal velocity profile generator for one straight move.
//
// A request on req_chan either starts a move (action = 1, with target_distance
// and exit_velocity) or advances the profile by one control tick (action = 0).
// Every request yields exactly one response on rsp_chan with the commanded
// velocity, the distance run so far, the phase and a done flag on completion.
// The csr_* port writes the cruise velocity limit, accel_step and decel_step;
// write it only while no request is in flight.
//
// Requests are processed one at a time by a microprogram. A tick while idle
// runs the dispatch and idle check steps and responds; a start runs LOAD, the
// three products and the settle step; a tick in a move runs a motion update in
// two steps before them. The response is registered in the last step, and
// req_chan.ready rises at that same edge; a new request is taken only after
// that. The three products share the one multiplier.
// A new request is taken while a response still waits in the output register;
// if the receiver stalls, the next request runs up to its response step and
// holds there until the output register is free.
// Synchronous reset clears the move state to idle, zero velocity and distance,
// loads the configuration defaults and empties the output register.
module trapezoid_move_profile_core (
   input  logic                                 clock,
   input  logic                                 reset,
   tmp_req_if.sink                              req_chan,
   tmp_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [tmp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tmp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tmp_pkg::*;

   logic          accept;
   logic          seq_ready;
   dp_ctrl_type   ctrl;
   dp_status_type status;

   // A request is taken when the sequencer has returned to its idle point.
   assign req_chan.ready = seq_ready;
   assign accept         = req_chan.valid && seq_ready;

   // Step counter and program table.
   tmp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .ready  (seq_ready),
      .ctrl   (ctrl)
   );

   // Move state, arithmetic and the response register.
   tmp_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_action          (req_chan.action),
      .req_target_distance (req_chan.target_distance),
      .req_exit_velocity   (req_chan.exit_velocity),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .ctrl                (ctrl),
      .status              (status),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_velocity_now    (rsp_chan.velocity_now),
      .rsp_distance_now    (rsp_chan.distance_now),
      .rsp_phase           (rsp_chan.phase),
      .rsp_done_res        (rsp_chan.done_res)
   );

endmodule

/* rtl/tmp_checker.sv */
// Checker: port-level assertions for the trapezoid move profile block, with its bind.
module tmp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tmp_pkg::TGT_W-1:0]         rsp_distance_now,
   input logic [tmp_pkg::PH_W-1:0]          rsp_phase,
   input logic                              rsp_done_res
);
   import tmp_pkg::*;

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The block works on one request at a time.
   a_busy_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in work");

   // Even the shortest program, a tick while idle, keeps the sequencer busy through its dispatch and idle check steps.
   a_busy_min: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 !req_ready)
      else $error("request finished faster than the shortest program");

   // A completed move reports idle with the distance cleared.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> (rsp_phase == PH_IDLE) && (rsp_distance_now == '0))
      else $error("done reported outside idle or with distance left");

endmodule

bind trapezoid_move_profile_core tmp_checker u_tmp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_distance_now (rsp_chan.distance_now),
   .rsp_phase        (rsp_chan.phase),
   .rsp_done_res     (rsp_chan.done_res)
);

/* verif/trapezoid_move_profile_core_tb.sv */
// Testbench for trapezoid_move_profile_core: random traffic checked against a motion predictor.
module trapezoid_move_profile_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tmp_pkg::*;

   // Register index 3 is not decoded; writes to it must leave the limits alone.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Saturation bounds of the velocity and of the distance, and the output cap.
   localparam longint VEL_TOP       = 64'sd2097151;
   localparam longint VEL_BOTTOM    = -64'sd2097152;
   localparam longint DIST_CAP      = 64'sd8589934591;
   localparam longint DIST_OUT_CAP  = 64'sd4294967295;

   // Cycle budget of the whole run; the run ends as failed when it is reached.
   localparam int CYCLE_LIMIT = 1000000;

   // One request as the sender presents it.
   typedef struct {
      logic              action;
      logic [TGT_W-1:0]  target_distance;
      logic [ENDV_W-1:0] exit_velocity;
   } move_req_type;

   // One response as the block should present it.
   typedef struct {
      logic signed [VEL_W-1:0] velocity_now;
      logic [TGT_W-1:0]        distance_now;
      phase_type               phase;
      logic                    done_res;
   } profile_rsp_type;

   // Motion state of one move. The numeric fields are wide signed integers so that
   // the squares and the braking product never overflow.
   typedef struct {
      longint    vel;
      longint    travel;
      phase_type ph;
      longint    goal;
      longint    goal_ev;
   } profile_state_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tmp_req_if req_chan();
   tmp_rsp_if rsp_chan();

   trapezoid_move_profile_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Limits as last written to the block. Both copies of the motion state
   // read them; they change only while the block is idle.
   logic [MAXV_W-1:0]    cfg_maxv;
   logic [STEP_SZ_W-1:0] cfg_accel;
   logic [STEP_SZ_W-1:0] cfg_decel;

   // planned_motion follows the requests as they are queued, so that the
   // stimulus knows when a move has completed. tracked_motion follows the
   // requests as the block accepts them and yields the predicted responses.
   profile_state_type planned_motion;
   profile_state_type tracked_motion;

   move_req_type    request_q[$];
   profile_rsp_type predicted_motion_q[$];

   int fail_count;
   int cycle_count;

   // Advances a motion state by one request and returns the response that
   // the block must give for it.
   function automatic void advance_profile(inout profile_state_type s,
                                           input move_req_type r,
                                           output profile_rsp_type o);
      longint acc;
      longint nd;
      longint mag;
      longint vv;
      longint ee;
      longint lhs;
      longint rhs;
      bit     brake;
      bit     done;
      done = 1'b0;
      if (r.action) begin
         // A start keeps the velocity and the distance it finds.
         s.goal    = r.target_distance;
         s.goal_ev = r.exit_velocity;
         s.ph      = PH_ACCEL;
      end else if (s.ph != PH_IDLE) begin
         if (s.ph == PH_ACCEL)
            acc = longint'(cfg_accel);
         else if (s.ph == PH_DECEL)
            acc = -longint'(cfg_decel);
         else
            acc = 0;
         s.vel = s.vel + acc;
         if (s.vel > VEL_TOP)
            s.vel = VEL_TOP;
         if (s.vel < VEL_BOTTOM)
            s.vel = VEL_BOTTOM;
         nd = s.travel + s.vel;
         if (nd < 0)
            nd = 0;
         if (nd > DIST_CAP)
            nd = DIST_CAP;
         s.travel = nd;
      end

      // Phase transitions; several may chain within one request. On an idle
      // tick none of them applies.
      if (s.ph == PH_ACCEL || s.ph == PH_CRUISE) begin
         if (s.travel >= s.goal) begin
            brake = 1'b1;
         end else begin
            mag   = (s.vel < 0) ? -s.vel : s.vel;
            vv    = mag * mag;
            ee    = s.goal_ev * s.goal_ev;
            lhs   = (vv >= ee) ? (vv - ee) : (ee - vv);
            rhs   = 2 * longint'(cfg_decel) * (s.goal - s.travel);
            brake = (lhs >= rhs);
         end
         if (brake)
            s.ph = PH_DECEL;
         else if (s.ph == PH_ACCEL && s.vel >= longint'(cfg_maxv))
            s.ph = PH_CRUISE;
      end
      if (s.ph == PH_DECEL) begin
         if (s.vel <= s.goal_ev || s.travel > s.goal) begin
            s.vel = s.goal_ev;
            if (s.goal_ev > 0) begin
               s.ph = PH_COAST;
            end else begin
               s.travel = 0;
               s.ph     = PH_IDLE;
               done     = 1'b1;
            end
         end
      end
      if (s.ph == PH_COAST && s.travel >= s.goal) begin
         s.travel = 0;
         s.ph     = PH_IDLE;
         done     = 1'b1;
      end

      o.velocity_now = s.vel[VEL_W-1:0];
      o.distance_now = (s.travel > DIST_OUT_CAP) ? '1 : s.travel[TGT_W-1:0];
      o.phase        = s.ph;
      o.done_res     = done;
   endfunction

   // Queues one request and moves the planning copy of the state along.
   task automatic queue_request(input logic action, input logic [TGT_W-1:0] goal,
                                input logic [ENDV_W-1:0] endv);
      move_req_type    r;
      profile_rsp_type ignored;
      r.action          = action;
      r.target_distance = goal;
      r.exit_velocity   = endv;
      advance_profile(planned_motion, r, ignored);
      request_q.push_back(r);
   endtask

   // Queues a start and then ticks until the move completes or max_ticks
   // ticks have been queued. Tick payloads are random since the block only
   // reads them on a start.
   task automatic queue_move(input logic [TGT_W-1:0] goal, input logic [ENDV_W-1:0] endv,
                             input int max_ticks, output int queued);
      int ticks;
      ticks = 0;
      queue_request(1'b1, goal, endv);
      while (planned_motion.ph != PH_IDLE && ticks < max_ticks) begin
         queue_request(1'b0, $urandom, ENDV_W'($urandom));
         ticks++;
      end
      queued = ticks + 1;
   endtask

   // Writes all three limits, then the undecoded index, one per clock. The
   // unused upper bits of the step registers carry random data.
   task automatic program_limits(input logic [MAXV_W-1:0] maxv,
                                 input logic [STEP_SZ_W-1:0] accel,
                                 input logic [STEP_SZ_W-1:0] decel);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CRUISE_LIMIT;
      csr_wdata <= maxv;
      @(posedge clock);
      csr_index <= CSR_ACCEL_STEP;
      csr_wdata <= {4'($urandom), accel};
      @(posedge clock);
      csr_index <= CSR_DECEL_STEP;
      csr_wdata <= {4'($urandom), decel};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_maxv  = maxv;
      cfg_accel = accel;
      cfg_decel = decel;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle budget: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Request driver. It sends bursts of random length with random gaps in
   // between, so that new requests land on every step of the block's
   // microprogram, and some bursts follow one another with no gap at all.
   // On every accepted request the tracked state is advanced and the
   // predicted response is stored.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin : drive_requests
      move_req_type    nxt;
      move_req_type    took;
      profile_rsp_type want;
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     = $urandom_range(1, 16);
         gap_left       = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            took.action          = req_chan.action;
            took.target_distance = req_chan.target_distance;
            took.exit_velocity   = req_chan.exit_velocity;
            advance_profile(tracked_motion, took, want);
            predicted_motion_q.push_back(want);
         end
         // The slot is free when nothing is offered or the offer was just taken.
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0 || request_q.size() == 0) begin
               req_chan.valid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end else begin
               nxt = request_q.pop_front();
               req_chan.valid           <= 1'b1;
               req_chan.action          <= nxt.action;
               req_chan.target_distance <= nxt.target_distance;
               req_chan.exit_velocity   <= nxt.exit_velocity;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Response monitor. Ready follows its own pattern: short stalls, short
   // open stretches, and now and then a long stretch with no stall at all.
   // Each accepted response is compared with the oldest prediction.
   int   ready_hold;
   logic ready_level;

   always @(posedge clock) begin : watch_responses
      profile_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_hold     = 0;
         ready_level    = 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_motion_q.size() == 0) begin
               $error("response with no request outstanding: velocity_now %0d distance_now %0d",
                      rsp_chan.velocity_now, rsp_chan.distance_now);
               fail_count++;
            end else begin
               want = predicted_motion_q.pop_front();
               if (rsp_chan.velocity_now !== want.velocity_now) begin
                  $error("velocity_now: expected %0d, actual %0d",
                         want.velocity_now, rsp_chan.velocity_now);
                  fail_count++;
               end
               if (rsp_chan.distance_now !== want.distance_now) begin
                  $error("distance_now: expected %0d, actual %0d",
                         want.distance_now, rsp_chan.distance_now);
                  fail_count++;
               end
               if (rsp_chan.phase !== want.phase) begin
                  $error("phase: expected %0d, actual %0d", want.phase, rsp_chan.phase);
                  fail_count++;
               end
               if (rsp_chan.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, actual %0d", want.done_res, rsp_chan.done_res);
                  fail_count++;
               end
            end
         end
         if (ready_hold > 0) begin
            ready_hold--;
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  ready_level = 1'b1;
                  ready_hold  = $urandom_range(100, 300);
               end
               1, 2, 3: begin
                  ready_level = 1'b0;
                  ready_hold  = $urandom_range(1, 14);
               end
               default: begin
                  ready_level = 1'b1;
                  ready_hold  = $urandom_range(0, 6);
               end
            endcase
         end
         rsp_chan.ready <= ready_level;
      end
   end

   // Stimulus sequence: reset, a directed part under the reset limits, then
   // eight phases of random moves, each under limits of its own, with the
   // limits rewritten only once every response of the previous phase is in.
   initial begin : run_sequence
      int                   phase_idx;
      int                   budget;
      int                   made;
      int                   queued;
      int                   span;
      int                   cap;
      int                   maxv_pick;
      int                   accel_pick;
      int                   decel_pick;
      int                   drain_wait;
      logic [TGT_W-1:0]     goal_pick;
      logic [ENDV_W-1:0]    endv_pick;

      // Every input is known from time zero.
      reset                    = 1'b1;
      csr_we                   = 1'b0;
      csr_index                = CSR_CRUISE_LIMIT;
      csr_wdata                = '0;
      req_chan.valid           = 1'b0;
      req_chan.action          = 1'b0;
      req_chan.target_distance = '0;
      req_chan.exit_velocity   = '0;
      rsp_chan.ready           = 1'b0;
      fail_count               = 0;
      cycle_count              = 0;

      cfg_maxv  = MAXV_RESET;
      cfg_accel = ACCEL_RESET;
      cfg_decel = DECEL_RESET;
      planned_motion = '{vel: 0, travel: 0, ph: PH_IDLE, goal: 0, goal_ev: 0};
      tracked_motion = planned_motion;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset limits.
      // A tick while idle, with every payload bit set, must change nothing.
      queue_request(1'b0, '1, '1);
      // A zero-length move completes on its own start request.
      queue_move(32'd0, 20'd0, 0, queued);
      // A short move that stops at zero velocity: accelerate, brake, done.
      queue_move(32'd3000, 20'd0, 12, queued);
      // A nonzero end velocity, so the move ends with a coast.
      queue_move(32'd12000, 20'd700, 12, queued);
      // Largest goal and end velocity, starting from the leftover velocity;
      // only a few ticks, then a new start replaces the goal mid-move.
      queue_move('1, '1, 3, queued);
      // The new goal is already behind: the distance has passed it.
      queue_move(32'd100, 20'd0, 2, queued);
      // Tick after completion.
      queue_request(1'b0, 32'd0, 20'd0);

      for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
         // Let the block go idle before touching its registers.
         while (request_q.size() != 0 || req_chan.valid || predicted_motion_q.size() != 0)
            @(negedge clock);
         repeat (12) @(negedge clock);

         accel_pick = $urandom_range(1, 65535);
         maxv_pick  = accel_pick * $urandom_range(1, 12);
         if (maxv_pick > 1048575)
            maxv_pick = 1048575;
         decel_pick = maxv_pick / $urandom_range(1, 30);
         if (decel_pick < 1)
            decel_pick = 1;
         if (decel_pick > 65535)
            decel_pick = 65535;
         budget = 265;
         case (phase_idx)
            0: begin
               // Upper extremes of all three limits.
               maxv_pick  = 1048575;
               accel_pick = 65535;
               decel_pick = 65535;
            end
            2: begin
               // Lower extremes: no cruise speed, no acceleration, slowest braking.
               maxv_pick  = 0;
               accel_pick = 0;
               decel_pick = 1;
               budget     = 100;
            end
            3: begin
               // Zero deceleration: braking is always due and never slows down.
               decel_pick = 0;
               budget     = 100;
            end
            default: ;
         endcase
         program_limits(MAXV_W'(maxv_pick), STEP_SZ_W'(accel_pick), STEP_SZ_W'(decel_pick));

         span = (cfg_maxv == 0) ? 1000 : int'(cfg_maxv);
         made = 0;
         while (made < budget) begin
            if ($urandom_range(0, 99) < 4) begin
               // Noise: a stray tick, often on an idle block.
               queue_request(1'b0, $urandom, ENDV_W'($urandom));
            end else begin
               case ($urandom_range(0, 9))
                  0:       goal_pick = '0;
                  1:       goal_pick = $urandom;
                  2:       goal_pick = $urandom_range(0, 3 * span);
                  default: goal_pick = span * $urandom_range(1, 25) + $urandom_range(0, span);
               endcase
               case ($urandom_range(0, 9))
                  5, 6, 7: endv_pick = ENDV_W'($urandom_range(0, span));
                  8:       endv_pick = ENDV_W'($urandom);
                  9:       endv_pick = '1;
                  default: endv_pick = '0;
               endcase
               // Most moves run to completion; some are cut short by the
               // next start.
               if ($urandom_range(0, 7) == 0)
                  cap = $urandom_range(0, 10);
               else
                  cap = $urandom_range(20, 150);
               queue_move(goal_pick, endv_pick, cap, queued);
               made += queued;
            end
         end
      end

      // Wait for the last request to go out and every response to come back.
      while (request_q.size() != 0 || req_chan.valid)
         @(negedge clock);
      drain_wait = 0;
      while (predicted_motion_q.size() != 0 && drain_wait < 5000) begin
         @(negedge clock);
         drain_wait++;
      end
      if (predicted_motion_q.size() != 0) begin
         $error("%0d responses never arrived", predicted_motion_q.size());
         fail_count++;
      end
      // A few more cycles to catch any stray response.
      repeat (20) @(negedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
